>>> rtl/pic_pkg.sv
`default_nettype none
package pic_pkg;
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_RAISE = 2'd2;
  localparam logic [9:0] SPURIOUS_ID = 10'd1023;

  // Word handed along the chain of cells during a scan.
  typedef struct packed {
    logic       found;
    logic [7:0] prio;
    logic [9:0] id;
  } scan_t;
endpackage
`default_nettype wire

>>> rtl/pic_cell.sv
`default_nettype none
// One interrupt line: holds its state and compares its candidacy against the
// best word arriving from the lower-numbered neighbour.
module pic_cell #(
  parameter int unsigned LINE_ID = 0
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           set_en,
  input  wire logic           clr_en,
  input  wire logic           set_pend,
  input  wire logic           take,
  input  wire logic           clr_act,
  input  wire logic           wr_prio,
  input  wire logic           wr_tgt,
  input  wire logic [7:0]     wdata,
  input  wire logic [7:0]     pmask,
  input  wire pic_pkg::scan_t scan_in,
  output pic_pkg::scan_t      scan_out,
  output logic                en_o,
  output logic [7:0]          prio_o,
  output logic [7:0]          tgt_o,
  output logic                cand_o
);
  logic en_r, pend_r, act_r;
  logic [7:0] prio_r, tgt_r;
  logic tgt_ok;

  assign tgt_ok = (LINE_ID < 32) ? 1'b1 : tgt_r[0];
  assign cand_o = pend_r && en_r && !act_r && tgt_ok && (prio_r < pmask);
  assign en_o   = en_r;
  assign prio_o = prio_r;
  assign tgt_o  = (LINE_ID < 32) ? 8'h01 : tgt_r;

  always_comb begin
    scan_out = scan_in;
    if (cand_o && (!scan_in.found || prio_r < scan_in.prio)) begin
      scan_out.found = 1'b1;
      scan_out.prio  = prio_r;
      scan_out.id    = 10'(LINE_ID);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b0;
      pend_r <= 1'b0;
      act_r  <= 1'b0;
      prio_r <= 8'h00;
      tgt_r  <= 8'h00;
    end else begin
      if (set_en) en_r <= 1'b1;
      else if (clr_en) en_r <= 1'b0;
      if (set_pend) pend_r <= 1'b1;
      else if (take) pend_r <= 1'b0;
      if (take) act_r <= 1'b1;
      else if (clr_act) act_r <= 1'b0;
      if (wr_prio) prio_r <= wdata;
      if (wr_tgt && LINE_ID >= 32) tgt_r <= wdata;
    end
  end
endmodule
`default_nettype wire

>>> rtl/priority_interrupt_controller_core.sv
// Sequencing: a word is captured on acceptance; a read of the acknowledge
// register then runs a scan that moves through the cell chain eight lines per
// cycle (ST_SCAN) before ST_DONE, where every other word goes straight; ST_DONE
// registers the result and applies the update. One word in flight at a time
// (busy high); the next word can be accepted once busy falls after out_valid.
// Each result appears for one cycle with out_valid; the receiver cannot stall.
// Reset (rst_n low, synchronous) clears all line state and control flags.
`default_nettype none
module priority_interrupt_controller_core #(
  parameter int unsigned NUM_IRQ = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [12:0] in_address,
  input  wire logic [31:0] in_write_data,
  input  wire logic [3:0]  in_byte_enable,
  input  wire logic [5:0]  in_irq_line,
  output logic             out_valid,
  output logic [31:0]      out_read_data,
  output logic             out_irq_request
);
  localparam int unsigned SEG    = 8;
  localparam int unsigned NSEG   = (NUM_IRQ + SEG - 1) / SEG;
  localparam int unsigned SW     = (NSEG > 1) ? $clog2(NSEG) : 1;
  localparam int unsigned IW     = $clog2(NUM_IRQ);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]  st_r, st_nxt;
  logic [1:0]  act_r;
  logic [12:0] addr_r;
  logic [31:0] wd_r;
  logic [3:0]  be_r;
  logic [5:0]  line_r;
  logic [SW-1:0] seg_r;
  pic_pkg::scan_t best_r;
  logic dist_on_r, cpu_on_r;
  logic [7:0] pmask_r;
  logic [31:0] rd_r;
  logic valid_r;

  logic [NUM_IRQ-1:0] en_v, cand_v;
  logic [7:0] prio_v [NUM_IRQ];
  logic [7:0] tgt_v  [NUM_IRQ];
  pic_pkg::scan_t chain [NUM_IRQ+1];
  pic_pkg::scan_t seg_res [NSEG];

  logic [31:0] wd_m;
  logic is_ack, do_take, cmd;
  assign wd_m = wd_r & {{8{be_r[3]}}, {8{be_r[2]}}, {8{be_r[1]}}, {8{be_r[0]}}};
  assign cmd = start && !busy;
  assign is_ack = (act_r == pic_pkg::ACT_READ) && (addr_r == 13'h100C);
  assign do_take = (st_r == ST_DONE) && is_ack && best_r.found && dist_on_r && cpu_on_r;

  // Segments restart the chain every eight cells; the sequencer walks them.
  genvar g;
  generate
    for (g = 0; g < NUM_IRQ; g++) begin : g_cell
      logic [7:0] wofs;
      logic [1:0] lane;
      logic se, ce, sp, ca, wp, wt;
      pic_pkg::scan_t sin;
      assign lane = 2'(g % 4);
      assign sin  = (g % SEG == 0) ? '0 : chain[g];
      assign wofs = 8'(g / 4);
      assign se = (act_r == pic_pkg::ACT_WRITE) && (addr_r[12:7] == 6'h02)
                  && (addr_r[6:2] == 5'(g / 32)) && wd_m[g % 32];
      assign ce = (act_r == pic_pkg::ACT_WRITE) && (addr_r[12:7] == 6'h03)
                  && (addr_r[6:2] == 5'(g / 32)) && wd_m[g % 32];
      assign sp = (act_r == pic_pkg::ACT_RAISE) && (32'(line_r) == g);
      assign ca = (act_r == pic_pkg::ACT_WRITE) && (addr_r == 13'h1010)
                  && (be_r != 4'h0) && (wd_m[9:0] == 10'(g));
      assign wp = (act_r == pic_pkg::ACT_WRITE) && (addr_r[12:10] == 3'b001)
                  && (addr_r[9:2] == wofs) && be_r[lane];
      assign wt = (act_r == pic_pkg::ACT_WRITE) && (addr_r[12:10] == 3'b010)
                  && (addr_r[9:2] == wofs) && be_r[lane];
      pic_cell #(.LINE_ID(g)) u_cell (
        .clk(clk), .rst_n(rst_n),
        .set_en(se && st_r == ST_DONE), .clr_en(ce && st_r == ST_DONE),
        .set_pend(sp && st_r == ST_DONE),
        .take(do_take && best_r.id == 10'(g)),
        .clr_act(ca && st_r == ST_DONE),
        .wr_prio(wp && st_r == ST_DONE), .wr_tgt(wt && st_r == ST_DONE),
        .wdata(wd_m[8*lane +: 8]), .pmask(pmask_r),
        .scan_in(sin), .scan_out(chain[g+1]),
        .en_o(en_v[g]), .prio_o(prio_v[g]), .tgt_o(tgt_v[g]), .cand_o(cand_v[g])
      );
    end
    for (g = 0; g < NSEG; g++) begin : g_seg
      assign seg_res[g] = chain[((g + 1) * SEG < NUM_IRQ) ? (g + 1) * SEG : NUM_IRQ];
    end
  endgenerate
  assign chain[0] = '0;

  // Register file read for everything but the acknowledge.
  logic [31:0] rd_c;
  always_comb begin
    logic [9:0] lid;
    rd_c = 32'h0;
    lid = 10'h0;
    if (addr_r == 13'h0000) rd_c = {31'h0, dist_on_r};
    else if (addr_r[12:8] == 5'h01) begin
      for (int b = 0; b < 32; b++) begin
        lid = {addr_r[6:2], 5'(b)};
        if (32'(lid) < NUM_IRQ) rd_c[b] = en_v[lid[IW-1:0]];
      end
    end else if (addr_r[12:10] == 3'b001 || addr_r[12:10] == 3'b010) begin
      for (int k = 0; k < 4; k++) begin
        lid = {addr_r[9:2], 2'(k)};
        if (32'(lid) < NUM_IRQ)
          rd_c[8*k +: 8] = addr_r[11] ? tgt_v[lid[IW-1:0]] : prio_v[lid[IW-1:0]];
      end
    end else if (addr_r == 13'h1000) rd_c = {31'h0, cpu_on_r};
    else if (addr_r == 13'h1004) rd_c = {24'h0, pmask_r};
  end

  pic_pkg::scan_t cur;
  logic cur_better;
  assign cur = seg_res[seg_r];
  assign cur_better = cur.found && (!best_r.found || cur.prio < best_r.prio);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (cmd) st_nxt = ((in_action == pic_pkg::ACT_READ)
                                  && (in_address[12:2] == 11'h403)) ? ST_SCAN : ST_DONE;
      ST_SCAN: if (32'(seg_r) == NSEG - 1) st_nxt = ST_DONE;
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      valid_r <= 1'b0;
      dist_on_r <= 1'b0;
      cpu_on_r <= 1'b0;
      pmask_r <= 8'h00;
      seg_r <= '0;
      best_r <= '0;
    end else begin
      st_r <= st_nxt;
      valid_r <= (st_r == ST_DONE);
      if (cmd) begin
        seg_r <= '0;
        best_r <= '0;
      end else if (st_r == ST_SCAN) begin
        seg_r <= seg_r + 1'b1;
        if (cur_better) best_r <= cur;
      end
      if (st_r == ST_DONE && act_r == pic_pkg::ACT_WRITE && be_r[0]) begin
        if (addr_r == 13'h0000) dist_on_r <= wd_r[0];
        if (addr_r == 13'h1000) cpu_on_r <= wd_r[0];
        if (addr_r == 13'h1004) pmask_r <= wd_r[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd) begin
      act_r  <= in_action;
      addr_r <= {in_address[12:2], 2'b00};
      wd_r   <= in_write_data;
      be_r   <= in_byte_enable;
      line_r <= in_irq_line;
    end
    if (st_r == ST_DONE) begin
      if (act_r != pic_pkg::ACT_READ) rd_r <= 32'h0;
      else if (is_ack)
        rd_r <= (best_r.found && dist_on_r && cpu_on_r) ? {22'h0, best_r.id}
                                                        : {22'h0, pic_pkg::SPURIOUS_ID};
      else rd_r <= rd_c;
    end
  end

  // Request is evaluated from the live cell state after the step has landed.
  assign busy = (st_r != ST_IDLE) || valid_r;
  assign out_valid = valid_r;
  assign out_read_data = rd_r;
  assign out_irq_request = dist_on_r && cpu_on_r && (|cand_v);
endmodule
`default_nettype wire
